@@ sv/lzc_pkg.sv @@
// ----------------------------------------------------------------------------
// lzc_pkg: shared types and constants of the Laplacian zero-crossing detector
// Sample and window types, request structs and the configuration register map.
// ----------------------------------------------------------------------------
package lzc_pkg;

  localparam int MAX_WIDTH   = 2048;
  localparam int SAMPLE_BITS = 16;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WEFF_BITS   = COL_BITS + 1;
  localparam int WIDTH_BITS  = 12;
  localparam int HEIGHT_BITS = 16;
  localparam int CONTR_BITS  = 16;
  localparam int CFG_BITS    = 16;
  localparam int MIN_SIZE    = 3;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_IMAGE_HEIGHT = 2'd1,
    REG_THRESHOLD    = 2'd2
  } reg_idx_e;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RST    = WIDTH_BITS'(640);
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RST   = HEIGHT_BITS'(480);
  localparam logic [CONTR_BITS-1:0]  CONTRAST_RST = CONTR_BITS'(240);

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef sample_t [8:0] win_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] laplacian_sample;
    logic                          frame_start;
  } in_req_t;

  typedef struct packed {
    logic edge_res;
    logic last;
  } out_req_t;

  // Position of one accepted sample, as seen by the pipeline.
  typedef struct packed {
    logic [COL_BITS-1:0] col;
    logic                emit;
    logic                last;
  } pos_t;

endpackage

@@ sv/lzc_ram.sv @@
// ----------------------------------------------------------------------------
// lzc_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module lzc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lzc_scan.sv @@
// ----------------------------------------------------------------------------
// lzc_scan: raster position tracker
// Column and row counters with frame restart, size clamping and wrap.
// ----------------------------------------------------------------------------
module lzc_scan (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           accept_i,
  input  logic                           frame_start_i,
  input  logic [lzc_pkg::WIDTH_BITS-1:0] image_width_i,
  input  logic [lzc_pkg::HEIGHT_BITS-1:0] image_height_i,
  output lzc_pkg::pos_t                  pos_o
);

  import lzc_pkg::*;

  logic [COL_BITS-1:0]    col_q, col_d;
  logic [HEIGHT_BITS-1:0] row_q, row_d;
  logic [WEFF_BITS-1:0]   w_eff;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic [COL_BITS-1:0]    col_start;
  logic [HEIGHT_BITS:0]   row_start;
  logic [COL_BITS-1:0]    col;
  logic [HEIGHT_BITS-1:0] row;
  logic [WEFF_BITS-1:0]   col_inc;
  logic [HEIGHT_BITS:0]   row_inc;

  always_comb begin
    if (image_width_i < WIDTH_BITS'(MIN_SIZE)) begin
      w_eff = WEFF_BITS'(MIN_SIZE);
    end else if ({1'b0, image_width_i} > (WIDTH_BITS+1)'(MAX_WIDTH)) begin
      w_eff = WEFF_BITS'(MAX_WIDTH);
    end else begin
      w_eff = WEFF_BITS'(image_width_i);
    end
    h_eff = (image_height_i < HEIGHT_BITS'(MIN_SIZE)) ? HEIGHT_BITS'(MIN_SIZE)
                                                      : image_height_i;

    // Position of the incoming sample, after restart and any wrap from a resize.
    col_start = frame_start_i ? '0 : col_q;
    row_start = frame_start_i ? '0 : {1'b0, row_q};
    if ({1'b0, col_start} >= w_eff) begin
      col_start = '0;
      row_start = row_start + 1'b1;
    end
    if (row_start >= {1'b0, h_eff}) begin
      row_start = '0;
    end
    col = col_start;
    row = row_start[HEIGHT_BITS-1:0];

    // Position that the following sample will take.
    col_inc = {1'b0, col} + 1'b1;
    row_inc = {1'b0, row} + 1'b1;
    if (col_inc >= w_eff) begin
      col_d = '0;
      row_d = (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HEIGHT_BITS-1:0];
    end else begin
      col_d = col_inc[COL_BITS-1:0];
      row_d = row;
    end

    pos_o.col  = col;
    pos_o.emit = (row >= HEIGHT_BITS'(2)) && (col >= COL_BITS'(2));
    pos_o.last = (row == h_eff - 1'b1) && ({1'b0, col} == w_eff - 1'b1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (accept_i) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

@@ sv/lzc_xing.sv @@
// ----------------------------------------------------------------------------
// lzc_xing: zero-crossing test on a 3x3 window
// Compares the centre with its eight neighbours in parallel.
// ----------------------------------------------------------------------------
module lzc_xing (
  input  lzc_pkg::win_t                  win_i,
  input  logic [lzc_pkg::CONTR_BITS-1:0] threshold_i,
  output logic                           edge_o
);

  import lzc_pkg::*;

  logic signed [SAMPLE_BITS:0] diff [9];
  logic        [SAMPLE_BITS:0] mag  [9];
  logic        [8:0]           hit;
  sample_t                     ctr;

  always_comb begin
    ctr = win_i[4];
    for (int k = 0; k < 9; k++) begin
      diff[k] = (SAMPLE_BITS+1)'(ctr) - (SAMPLE_BITS+1)'(win_i[k]);
      mag[k]  = diff[k][SAMPLE_BITS] ? (SAMPLE_BITS+1)'(-diff[k])
                                     : (SAMPLE_BITS+1)'(diff[k]);
      // Opposite strict signs only; a zero on either side never counts.
      hit[k]  = (k != 4)
             && (((ctr > 0) && (win_i[k] < 0)) || ((ctr < 0) && (win_i[k] > 0)))
             && (mag[k] >= (SAMPLE_BITS+1)'(threshold_i));
    end
    edge_o = |hit;
  end

endmodule

@@ sv/laplacian_zero_crossing_detector.sv @@
// ----------------------------------------------------------------------------
// laplacian_zero_crossing_detector: streaming 3x3 zero-crossing edge detector
// Line buffers, sliding window and edge decision for a raster Laplacian frame.
// ----------------------------------------------------------------------------
// The block takes one signed Q12.4 Laplacian sample per request in raster
// order and, once a sample completes the 3x3 neighbourhood of an interior
// pixel, returns one result with edge_res set when some neighbour has the
// strictly opposite sign and differs from the centre by at least the
// contrast threshold. Border pixels give no result, and last marks the final
// interior pixel of a frame. A sample with frame_start set restarts the
// raster counters; after the last pixel the counters also wrap on their own.
// The block sustains one sample per clock while out_ready_i stays high: the
// sample is registered while both line buffers are read, then the window
// shifts and the buffers are written back, and then the window is evaluated
// into the output register.
// The two line buffers are single-write, single-read RAMs of MAX_WIDTH
// samples each; they are not cleared after reset, so the first two rows of
// a frame read whatever the buffers hold, which only affects border pixels.
// Configuration is taken at any time through the register port and must be
// written while no request is in flight.
// ----------------------------------------------------------------------------
module laplacian_zero_crossing_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  lzc_pkg::in_req_t             in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output lzc_pkg::out_req_t            out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [1:0]                   cfg_index_i,
  input  logic [lzc_pkg::CFG_BITS-1:0] cfg_data_i
);

  import lzc_pkg::*;

  // Configuration registers.
  logic [WIDTH_BITS-1:0]  width_q;
  logic [HEIGHT_BITS-1:0] height_q;
  logic [CONTR_BITS-1:0]  contrast_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q    <= WIDTH_RST;
      height_q   <= HEIGHT_RST;
      contrast_q <= CONTRAST_RST;
    end else if (cfg_valid_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  width_q    <= cfg_data_i[WIDTH_BITS-1:0];
        REG_IMAGE_HEIGHT: height_q   <= cfg_data_i[HEIGHT_BITS-1:0];
        REG_THRESHOLD:    contrast_q <= cfg_data_i[CONTR_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake. Each stage moves on when the one after it has room,
  // so a parked output result stops new requests only when both stages are full.
  logic a_vld_q;      // sample stage holds a request
  logic w_pend_q;     // window holds a result not yet moved to the output
  logic out_vld_q;
  logic accept;
  logic b_adv;
  logic out_load;
  logic out_free;

  assign out_free   = !out_vld_q || out_ready_i;
  assign out_load   = w_pend_q && out_free;
  assign b_adv      = a_vld_q && (!w_pend_q || out_load);
  assign in_ready_o = !a_vld_q || b_adv;
  assign accept     = in_valid_i && in_ready_o;

  // Raster position of the incoming sample.
  pos_t pos;

  lzc_scan u_scan (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .frame_start_i  (in_data_i.frame_start),
    .image_width_i  (width_q),
    .image_height_i (height_q),
    .pos_o          (pos)
  );

  // Sample stage registers.
  sample_t             smp_a_q;
  logic [COL_BITS-1:0] col_a_q;
  logic                emit_a_q;
  logic                last_a_q;
  logic                fwd_q;
  sample_t             fwd_top_q;
  sample_t             fwd_mid_q;

  // Line buffers: mid holds the previous row, top the one before it.
  logic [SAMPLE_BITS-1:0] rd_top, rd_mid;
  sample_t                top_val, mid_val;

  lzc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_top (
    .clk_i   (clk_i),
    .we_i    (b_adv),
    .waddr_i (col_a_q),
    .wdata_i (mid_val),
    .re_i    (accept),
    .raddr_i (pos.col),
    .rdata_o (rd_top)
  );

  lzc_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WIDTH)
  ) u_line_mid (
    .clk_i   (clk_i),
    .we_i    (b_adv),
    .waddr_i (col_a_q),
    .wdata_i (smp_a_q),
    .re_i    (accept),
    .raddr_i (pos.col),
    .rdata_o (rd_mid)
  );

  // Two back-to-back samples on the same column (a restart right after a
  // restart) read an entry in the same cycle it is written, so the written
  // values are forwarded around the buffers.
  assign top_val = fwd_q ? fwd_top_q : sample_t'(rd_top);
  assign mid_val = fwd_q ? fwd_mid_q : sample_t'(rd_mid);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (accept) begin
      a_vld_q <= 1'b1;
    end else if (b_adv) begin
      a_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      smp_a_q   <= in_data_i.laplacian_sample;
      col_a_q   <= pos.col;
      emit_a_q  <= pos.emit;
      last_a_q  <= pos.last;
      fwd_q     <= b_adv && (col_a_q == pos.col);
      fwd_top_q <= mid_val;
      fwd_mid_q <= smp_a_q;
    end
  end

  // Window stage: the three newest samples enter the right-hand column.
  win_t win_q;
  logic w_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q    <= '0;
      w_pend_q <= 1'b0;
      w_last_q <= 1'b0;
    end else begin
      if (b_adv) begin
        for (int r = 0; r < 3; r++) begin
          win_q[r*3]     <= win_q[r*3 + 1];
          win_q[r*3 + 1] <= win_q[r*3 + 2];
        end
        win_q[2] <= top_val;
        win_q[5] <= mid_val;
        win_q[8] <= smp_a_q;
        w_pend_q <= emit_a_q;
        w_last_q <= last_a_q;
      end else if (out_load) begin
        w_pend_q <= 1'b0;
      end
    end
  end

  // Edge decision into the output register.
  logic     edge_w;
  out_req_t out_q;

  lzc_xing u_xing (
    .win_i       (win_q),
    .threshold_i (contrast_q),
    .edge_o      (edge_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.edge_res <= edge_w;
      out_q.last     <= w_last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule
